// ----- rtl/ehr_pkg.sv -----
// ----------------------------------------------------------------------------
// ehr_pkg
// Shared types and constants for the exponential histogram remap block.
// ----------------------------------------------------------------------------
`default_nettype none
package ehr_pkg;

    localparam int MW   = 32;            // normalized mantissa width, Q1.31
    localparam int EW   = 5;             // log2 integer part
    localparam int FW   = 16;            // log2 fraction bits
    localparam int LOGW = EW + FW;       // log2 value, Q5.16
    localparam int NLW  = 21;            // -ln(1-p) value, Q5.16
    localparam int SCW  = 13;            // scaled term after >> 24
    localparam int CFGW = 16;            // widest configuration register
    localparam int SQC_W = 5;            // squaring step counter

    localparam logic [FW-1:0]   LN2_Q16   = 16'd45426;
    localparam logic [7:0]      LEVEL_MAX = 8'd255;
    localparam logic [15:0]     INV_ALPHA_RST = 16'd8192;
    localparam logic [SQC_W-1:0] SQ_STEPS = 5'd16;

    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_MAP   = 1'b1;

    localparam logic REG_MIN_LEVEL = 1'b0;
    localparam logic REG_INV_ALPHA = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT_WR,
        S_SUM,
        S_CHECK,
        S_NORM_A,
        S_SQ_A,
        S_NORM_B,
        S_SQ_B,
        S_MUL1,
        S_MUL2,
        S_FIN,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        RES_MIN,
        RES_SAT,
        RES_CALC
    } t_res_kind;

    typedef struct packed {
        logic      load;       // capture input word
        logic      cnt_wr;     // write incremented bin, bump total
        logic      sum_step;   // one bin of the prefix sum
        logic      log_load;   // start a log2 on the selected operand
        logic      log_sel_b;  // operand: 0 total, 1 total - sum
        logic      norm;       // one normalize shift
        logic      sq;         // one squaring step
        logic      save_a;     // keep first log2 result
        logic      mul1;       // d * ln2
        logic      mul2;       // inverse_alpha * -ln(1-p)
        logic      res_load;   // latch final result
        t_res_kind res_kind;
        logic      out_load;   // move result to output register
    } t_cmd;

    typedef struct packed {
        logic total_zero;
        logic sum_ge;
        logic sum_done;
        logic norm_done;
        logic sq_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ----- rtl/ehr_in_if.sv -----
// ----------------------------------------------------------------------------
// ehr_in_if
// Input channel: valid/ready with operation, pixel and frame_start.
// ----------------------------------------------------------------------------
`default_nettype none
interface ehr_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] pixel;
    logic       frame_start;

    modport source (output valid, output operation, output pixel, output frame_start,
                    input ready);
    modport sink   (input valid, input operation, input pixel, input frame_start,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/ehr_out_if.sv -----
// ----------------------------------------------------------------------------
// ehr_out_if
// Output channel: valid/ready with mapped level and saturation flag.
// ----------------------------------------------------------------------------
`default_nettype none
interface ehr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] mapped;
    logic       saturated;

    modport source (output valid, output mapped, output saturated, input ready);
    modport sink   (input valid, input mapped, input saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/ehr_ram.sv -----
// ----------------------------------------------------------------------------
// ehr_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module ehr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/ehr_datapath.sv -----
// ----------------------------------------------------------------------------
// ehr_datapath
// Histogram store, prefix sum, shared log2 unit, scaling and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module ehr_datapath #(
    parameter int LEVELS      = 256,
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ehr_pkg::t_cmd        i_cmd,
    output ehr_pkg::t_sts             o_sts,
    input  wire logic                 i_operation,
    input  wire logic [7:0]           i_pixel,
    input  wire logic                 i_frame_start,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_idx,
    input  wire logic [ehr_pkg::CFGW-1:0] i_cfg_data,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [7:0]                o_mapped,
    output logic                      o_saturated
);
    import ehr_pkg::*;

    localparam int LW = $clog2(LEVELS);
    localparam int SW = COUNT_WIDTH + LW;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [7:0]             r_min_level;
    logic [15:0]            r_inv_alpha;
    logic [LEVELS-1:0]      r_bin_vld;
    logic [COUNT_WIDTH-1:0] r_total;
    logic [LW-1:0]          r_level;
    logic [LW:0]            r_idx;
    logic                   r_rd_pend;
    logic                   r_rd_vld;
    logic [SW-1:0]          r_sum;
    logic [MW-1:0]          r_m;
    logic [EW-1:0]          r_e;
    logic [FW-1:0]          r_frac;
    logic [SQC_W-1:0]       r_sqc;
    logic [LOGW-1:0]        r_la;
    logic [NLW-1:0]         r_nl;
    logic [SCW-1:0]         r_scaled;
    logic [7:0]             r_res_mapped;
    logic                   r_res_sat;
    logic                   r_out_vld;
    logic [7:0]             r_out_mapped;
    logic                   r_out_sat;

    logic [LW-1:0]          n_level;
    logic [LW-1:0]          ram_raddr;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic [COUNT_WIDTH-1:0] bin_old;
    logic [COUNT_WIDTH-1:0] bin_new;
    logic [COUNT_WIDTH-1:0] diff;
    logic [2*MW-1:0]        sq_prod;
    logic [MW:0]            sq_top;
    logic [LOGW-1:0]        lb;
    logic [LOGW-1:0]        d;
    logic [LOGW+FW-1:0]     p1;
    logic [16+NLW-1:0]      p2;
    logic [SCW:0]           res_sum;

    assign n_level = (9'(i_pixel) >= 9'(LEVELS)) ? LW'(LEVELS - 1) : i_pixel[LW-1:0];
    assign ram_raddr = i_cmd.load ? n_level : r_idx[LW-1:0];

    ehr_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(LEVELS)) u_bins (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cnt_wr),
        .i_waddr (r_level),
        .i_wdata (bin_new),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // never-written bins read as zero
    assign bin_old = r_bin_vld[r_level] ? ram_rdata : '0;
    assign bin_new = (bin_old == CNT_MAX) ? bin_old : bin_old + 1'b1;
    assign diff    = r_total - r_sum[COUNT_WIDTH-1:0];
    assign sq_prod = (2*MW)'(r_m) * (2*MW)'(r_m);
    assign sq_top  = sq_prod[2*MW-1:MW-1];
    assign lb      = {r_e, r_frac};
    assign d       = (r_la > lb) ? r_la - lb : '0;
    assign p1      = (LOGW+FW)'(d) * (LOGW+FW)'(LN2_Q16);
    assign p2      = (16+NLW)'(r_inv_alpha) * (16+NLW)'(r_nl);
    assign res_sum = (SCW+1)'(r_min_level) + (SCW+1)'(r_scaled);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_level <= '0;
            r_inv_alpha <= INV_ALPHA_RST;
            r_bin_vld   <= '0;
            r_total     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MIN_LEVEL: r_min_level <= i_cfg_data[7:0];
                    REG_INV_ALPHA: r_inv_alpha <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load && i_operation == OP_COUNT && i_frame_start) begin
                r_bin_vld <= '0;
                r_total   <= '0;
            end
            if (i_cmd.cnt_wr) begin
                r_bin_vld[r_level] <= 1'b1;
                if (r_total != CNT_MAX) begin
                    r_total <= r_total + 1'b1;
                end
            end
            if (i_cmd.load) begin
                r_rd_pend <= 1'b0;
            end else if (i_cmd.sum_step) begin
                r_rd_pend <= (r_idx < (LW+1)'(r_level));
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_level <= n_level;
            r_idx   <= '0;
            r_sum   <= '0;
        end
        if (i_cmd.sum_step) begin
            if (r_idx < (LW+1)'(r_level)) begin
                r_rd_vld <= r_bin_vld[r_idx[LW-1:0]];
                r_idx    <= r_idx + 1'b1;
            end
            if (r_rd_pend && r_rd_vld) begin
                r_sum <= r_sum + SW'(ram_rdata);
            end
        end
        if (i_cmd.log_load) begin
            r_m    <= i_cmd.log_sel_b ? MW'(diff) : MW'(r_total);
            r_e    <= EW'(MW - 1);
            r_frac <= '0;
            r_sqc  <= '0;
        end else if (i_cmd.norm) begin
            r_m <= {r_m[MW-2:0], 1'b0};
            r_e <= r_e - 1'b1;
        end else if (i_cmd.sq) begin
            // square, keep Q1.31; a product at or above 2.0 yields a one bit
            r_m    <= sq_top[MW] ? sq_top[MW:1] : sq_top[MW-1:0];
            r_frac <= {r_frac[FW-2:0], sq_top[MW]};
            r_sqc  <= r_sqc + 1'b1;
        end
        if (i_cmd.save_a) begin
            r_la <= lb;
        end
        if (i_cmd.mul1) begin
            r_nl <= p1[FW+NLW-1:FW];
        end
        if (i_cmd.mul2) begin
            r_scaled <= p2[24+SCW-1:24];
        end
        if (i_cmd.res_load) begin
            case (i_cmd.res_kind)
                RES_MIN: begin
                    r_res_mapped <= r_min_level;
                    r_res_sat    <= 1'b0;
                end
                RES_SAT: begin
                    r_res_mapped <= LEVEL_MAX;
                    r_res_sat    <= 1'b1;
                end
                RES_CALC: begin
                    r_res_mapped <= (res_sum > (SCW+1)'(LEVEL_MAX)) ? LEVEL_MAX : res_sum[7:0];
                    r_res_sat    <= (res_sum > (SCW+1)'(LEVEL_MAX));
                end
                default: begin
                    r_res_mapped <= LEVEL_MAX;
                    r_res_sat    <= 1'b1;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_mapped <= r_res_mapped;
            r_out_sat    <= r_res_sat;
        end
    end

    always_comb begin
        o_sts.total_zero = (r_total == '0);
        o_sts.sum_ge     = (r_sum >= SW'(r_total));
        o_sts.sum_done   = (r_idx == (LW+1)'(r_level)) && !r_rd_pend;
        o_sts.norm_done  = r_m[MW-1];
        o_sts.sq_done    = (r_sqc == SQ_STEPS);
        o_sts.out_free   = !r_out_vld || i_out_ready;
    end

    assign o_out_valid = r_out_vld;
    assign o_mapped    = r_out_mapped;
    assign o_saturated = r_out_sat;
endmodule
`default_nettype wire

// ----- rtl/ehr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ehr_ctrl
// Sequencer: count update, prefix sum, two log2 passes, scaling, result.
// ----------------------------------------------------------------------------
`default_nettype none
module ehr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_operation,
    input  wire ehr_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output ehr_pkg::t_cmd      o_cmd
);
    import ehr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.res_kind = RES_CALC;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_operation == OP_MAP) ? S_SUM : S_CNT_WR;
                end
            end
            S_CNT_WR: begin
                o_cmd.cnt_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_sts.sum_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.total_zero) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = RES_MIN;
                    n_state = S_OUT;
                end else if (i_sts.sum_ge) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = RES_SAT;
                    n_state = S_OUT;
                end else begin
                    o_cmd.log_load = 1'b1;
                    n_state = S_NORM_A;
                end
            end
            S_NORM_A: begin
                if (i_sts.norm_done) begin
                    n_state = S_SQ_A;
                end else begin
                    o_cmd.norm = 1'b1;
                end
            end
            S_SQ_A: begin
                if (i_sts.sq_done) begin
                    o_cmd.save_a    = 1'b1;
                    o_cmd.log_load  = 1'b1;
                    o_cmd.log_sel_b = 1'b1;
                    n_state = S_NORM_B;
                end else begin
                    o_cmd.sq = 1'b1;
                end
            end
            S_NORM_B: begin
                if (i_sts.norm_done) begin
                    n_state = S_SQ_B;
                end else begin
                    o_cmd.norm = 1'b1;
                end
            end
            S_SQ_B: begin
                if (i_sts.sq_done) begin
                    n_state = S_MUL1;
                end else begin
                    o_cmd.sq = 1'b1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_kind = RES_CALC;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/exponential_histogram_remap.sv -----
// A count word is accepted in S_IDLE and its bin written in S_CNT_WR. A map
//   word runs, from accept to output load, the prefix sum over the bins below
//   its level (one read per cycle), up to 31 normalize shifts and 16 squarings
//   per log2 on the shared log unit (two passes), then the d * ln2 and
//   inverse_alpha multiplies. An empty histogram or a full bin sum skips the log2.
// One word at a time; a finished result waits in the output register.
// ----------------------------------------------------------------------------
// exponential_histogram_remap
// Two-pass histogram count and exponential gray-level remap.
// Synchronous active-low reset clears bin valid bits, total, min level and output valid.
// ----------------------------------------------------------------------------
`default_nettype none
module exponential_histogram_remap #(
    parameter int LEVELS      = 256,
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    ehr_in_if.sink                        i_in,
    ehr_out_if.source                     o_out,
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_idx,
    input  wire logic [ehr_pkg::CFGW-1:0] i_cfg_data
);
    import ehr_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_in.ready = in_ready;

    ehr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_operation (i_in.operation),
        .i_sts       (sts),
        .o_in_ready  (in_ready),
        .o_cmd       (cmd)
    );

    ehr_datapath #(.LEVELS(LEVELS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_operation   (i_in.operation),
        .i_pixel       (i_in.pixel),
        .i_frame_start (i_in.frame_start),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_mapped      (o_out.mapped),
        .o_saturated   (o_out.saturated)
    );
endmodule
`default_nettype wire

// ----- rtl/ehr_checker.sv -----
// ----------------------------------------------------------------------------
// ehr_checker
// Port-level checks on the remap block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module ehr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_mapped,
    input wire logic       i_saturated
);
    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_mapped))
        else $error("output word changed while stalled");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_saturated |-> i_mapped == 8'd255)
        else $error("saturated result not at full scale");

    // one word at a time: ready drops after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("accepted a second word back to back");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");
endmodule

bind exponential_histogram_remap ehr_checker u_ehr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_mapped    (o_out.mapped),
    .i_saturated (o_out.saturated)
);
`default_nettype wire
